[rtl/shared_two_stack_memory_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the shared two-stack memory
// Immediate-implication and next-cycle-implication checks, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHARED_TWO_STACK_MEMORY_ASSERT_SVH
`define SHARED_TWO_STACK_MEMORY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STSM_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STSM_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/stsm_pkg.sv]
// ----------------------------------------------------------------------------
// stsm_pkg
// Shared types and codes for the two-stack memory controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package stsm_pkg;

    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int IO_W   = 32;
    localparam int FREE_W = 5;

    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // evaluate the request, update pointers and memory
        logic reply;  // present the result
    } t_cmd;

endpackage

`default_nettype wire

[rtl/shared_two_stack_memory.sv]
// ----------------------------------------------------------------------------
// shared_two_stack_memory
// Two LIFO stacks in one memory, the lower growing up and the upper down.
// ----------------------------------------------------------------------------
// A request (push, pop or peek on one stack) is taken when start is high and
// busy is low. A request first checks the counts and accesses the single-port
// memory, then its result sits on the o_ ports with o_valid high. The result
// is shown for one cycle only and cannot be stalled; a new request may be
// started in that same cycle, so the block can take a new request while the
// last result is still shown. Stack words read only after they were pushed.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_two_stack_memory #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [stsm_pkg::REQ_W-1:0]         i_req_type,
    input  wire logic                               i_stack_sel,
    input  wire logic signed [stsm_pkg::IO_W-1:0]   i_push_value,
    output logic                                    o_valid,
    output logic [stsm_pkg::STAT_W-1:0]             o_status,
    output logic signed [stsm_pkg::IO_W-1:0]        o_read_value,
    output logic [stsm_pkg::FREE_W-1:0]             o_free_space,
    output logic                                    o_lower_empty,
    output logic                                    o_upper_empty
);

    stsm_pkg::t_cmd cmd;

    stsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    stsm_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_stack_sel   (i_stack_sel),
        .i_push_value  (i_push_value),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_free_space  (o_free_space),
        .o_lower_empty (o_lower_empty),
        .o_upper_empty (o_upper_empty)
    );

endmodule

`default_nettype wire

[rtl/stsm_ctrl.sv]
// ----------------------------------------------------------------------------
// stsm_ctrl
// Request sequencer: accept, execute, reply.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shared_two_stack_memory_assert.svh"

module stsm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               o_valid,
    output stsm_pkg::t_cmd     o_cmd
);

    stsm_pkg::t_state r_state;
    stsm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stsm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            stsm_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = stsm_pkg::ST_CHECK;
                end
            end
            stsm_pkg::ST_CHECK: begin
                n_state = stsm_pkg::ST_REPLY;
            end
            stsm_pkg::ST_REPLY: begin
                // A new request may be taken while the result is on the ports.
                if (start) begin
                    n_state = stsm_pkg::ST_CHECK;
                end else begin
                    n_state = stsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy        = 1'b0;
        o_valid     = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        o_cmd.reply = 1'b0;
        case (r_state)
            stsm_pkg::ST_IDLE: begin
                o_cmd.load = start;
            end
            stsm_pkg::ST_CHECK: begin
                busy       = 1'b1;
                o_cmd.exec = 1'b1;
            end
            stsm_pkg::ST_REPLY: begin
                o_valid     = 1'b1;
                o_cmd.reply = 1'b1;
                o_cmd.load  = start;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    `STSM_NEXT(a_check_then_reply, i_clk, i_rst_n, r_state == stsm_pkg::ST_CHECK, r_state == stsm_pkg::ST_REPLY, "execute cycle not followed by reply")
    `STSM_CHECK(a_reply_after_check, i_clk, i_rst_n, r_state == stsm_pkg::ST_REPLY, $past(r_state) == stsm_pkg::ST_CHECK, "reply without a preceding execute cycle")

endmodule

`default_nettype wire

[rtl/stsm_datapath.sv]
// ----------------------------------------------------------------------------
// stsm_datapath
// Shared word memory, the two stack counts and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shared_two_stack_memory_assert.svh"

module stsm_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire stsm_pkg::t_cmd                     i_cmd,
    input  wire logic [stsm_pkg::REQ_W-1:0]         i_req_type,
    input  wire logic                               i_stack_sel,
    input  wire logic signed [stsm_pkg::IO_W-1:0]   i_push_value,
    output logic [stsm_pkg::STAT_W-1:0]             o_status,
    output logic signed [stsm_pkg::IO_W-1:0]        o_read_value,
    output logic [stsm_pkg::FREE_W-1:0]             o_free_space,
    output logic                                    o_lower_empty,
    output logic                                    o_upper_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] r_mem_q;

    logic [stsm_pkg::REQ_W-1:0]   r_req_type;
    logic                         r_stack_sel;
    logic [DATA_WIDTH-1:0]        r_word;
    logic [CW-1:0]                r_lower_count;
    logic [CW-1:0]                r_upper_count;
    logic [stsm_pkg::STAT_W-1:0]  r_status;
    logic                         r_rd_hit;

    logic [stsm_pkg::STAT_W-1:0]  n_status;
    logic signed [63:0]           push_ext;
    logic signed [63:0]           rd_ext;
    logic [CW-1:0]                used;
    logic [CW-1:0]                free_words;
    logic [CW-1:0]                sel_count;
    logic                         is_push;
    logic                         is_pop;
    logic                         is_read;
    logic                         full;
    logic                         wr_en;
    logic                         rd_en;
    logic [CW-1:0]                waddr_full;
    logic [CW-1:0]                raddr_full;
    logic [AW-1:0]                waddr;
    logic [AW-1:0]                raddr;

    assign push_ext   = 64'(i_push_value);
    assign used       = r_lower_count + r_upper_count;
    assign free_words = CW'(DEPTH) - used;
    assign sel_count  = r_stack_sel ? r_upper_count : r_lower_count;
    assign is_push    = (r_req_type == stsm_pkg::REQ_PUSH);
    assign is_pop     = (r_req_type == stsm_pkg::REQ_POP);
    assign is_read    = is_pop || (r_req_type == stsm_pkg::REQ_PEEK);
    assign full       = (used >= CW'(DEPTH));
    assign wr_en      = i_cmd.exec && is_push && !full;
    assign rd_en      = i_cmd.exec && is_read && (sel_count != '0);

    // The upper stack grows down from the top word.
    assign waddr_full = r_stack_sel ? (CW'(DEPTH - 1) - r_upper_count) : r_lower_count;
    assign raddr_full = r_stack_sel ? (CW'(DEPTH) - r_upper_count) : (r_lower_count - 1'b1);
    assign waddr      = waddr_full[AW-1:0];
    assign raddr      = raddr_full[AW-1:0];

    always_comb begin
        n_status = stsm_pkg::STAT_DONE;
        if (is_push && full) begin
            n_status = stsm_pkg::STAT_FULL;
        end else if (is_read && (sel_count == '0)) begin
            n_status = stsm_pkg::STAT_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr] <= signed'(r_word);
        end
        if (rd_en) begin
            r_mem_q <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type  <= i_req_type;
            r_stack_sel <= i_stack_sel;
            r_word      <= push_ext[DATA_WIDTH-1:0];
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd_hit <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_count <= '0;
            r_upper_count <= '0;
        end else if (wr_en) begin
            if (r_stack_sel) begin
                r_upper_count <= r_upper_count + 1'b1;
            end else begin
                r_lower_count <= r_lower_count + 1'b1;
            end
        end else if (rd_en && is_pop) begin
            if (r_stack_sel) begin
                r_upper_count <= r_upper_count - 1'b1;
            end else begin
                r_lower_count <= r_lower_count - 1'b1;
            end
        end
    end

    assign rd_ext        = 64'(r_mem_q);
    assign o_status      = r_status;
    assign o_read_value  = r_rd_hit ? $signed(rd_ext[stsm_pkg::IO_W-1:0]) : '0;
    assign o_free_space  = stsm_pkg::FREE_W'(free_words);
    assign o_lower_empty = (r_lower_count == '0);
    assign o_upper_empty = (r_upper_count == '0);

    `STSM_CHECK(a_used_bound, i_clk, i_rst_n, 1'b1, used <= CW'(DEPTH), "stacks hold more words than the memory")
    `STSM_NEXT(a_refused_hold, i_clk, i_rst_n, i_cmd.exec && (n_status != stsm_pkg::STAT_DONE), $stable(r_lower_count) && $stable(r_upper_count), "refused request changed a stack count")

endmodule

`default_nettype wire
